// ===== rtl/tkl_pkg.sv =====
// Package for the top-k largest tracker.
// Holds field widths, the register reset value and the kept-entry type.
// No dependencies.
package tkl_pkg;

  localparam int unsigned TopMaxDefault = 32;
  localparam int unsigned SizeW         = 48;
  localparam int unsigned TagW          = 32;
  localparam int unsigned RankW         = 5;
  localparam int unsigned FilesW        = 32;
  localparam int unsigned BytesW        = 63;
  localparam int unsigned TopCountW     = 6;
  localparam logic [TopCountW-1:0] TopCountReset = 6'd20;

  localparam logic ActionAdd  = 1'b0;
  localparam logic ActionRead = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [TagW-1:0]  tag;
  } entry_t;

endpackage

// ===== rtl/top_k_largest_tracker.sv =====
// Top level of the top-k largest tracker: sorted entry memory and its sequencer.
// Depends on tkl_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   action_i selects add (file_size_i, file_tag_i) or read (read_rank_i).
//   Output channel (out_valid_o / out_stall_i) returns one transaction per item.
//   The list, largest size first, lives in one memory of TOP_MAX entries with
//   a registered read. An add walks from the free or smallest slot toward
//   rank 0, one entry a cycle, moving smaller entries down by one.
//   A read, or an add with tracking off, goes straight to the output register;
//   an add that a full list rejects first compares with the smallest entry,
//   and an insertion walks over the single read port. One item is in work at
//   a time; in_stall_o is high until its result is loaded, and the next item
//   can be taken in the cycle after. While out_stall_i holds a result, the
//   next transaction is still taken and then waits before its result is loaded.
//   Reset clears the counters and the kept count and sets top_count to 20;
//   memory contents need no clearing. The user must write top_count through
//   cfg_we_i only while idle; the block itself does not enforce it.
module top_k_largest_tracker
  import tkl_pkg::*;
#(
  parameter int unsigned TOP_MAX = TopMaxDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [TopCountW-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [SizeW-1:0]     file_size_i,
  input  logic [TagW-1:0]      file_tag_i,
  input  logic [RankW-1:0]     read_rank_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 was_inserted_o,
  output logic [RankW-1:0]     insert_rank_o,
  output logic [FilesW-1:0]    files_seen_o,
  output logic [BytesW-1:0]    bytes_seen_o,
  output logic                 entry_valid_o,
  output logic [SizeW-1:0]     entry_size_o,
  output logic [TagW-1:0]      entry_tag_o
);

  localparam int unsigned AW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
  localparam int unsigned CW = $clog2(TOP_MAX + 1);

  typedef enum logic [5:0] {
    IDLE  = 6'b000001,
    CHK   = 6'b000010,
    SCAN  = 6'b000100,
    PLACE = 6'b001000,
    DONE  = 6'b010000,
    SPARE = 6'b100000
  } state_e;

  function automatic logic [CW-1:0] limit_of(input logic [TopCountW-1:0] tc);
    if ({3'b000, tc} < 9'(TOP_MAX)) begin
      return CW'(tc);
    end
    return CW'(TOP_MAX);
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      kept_count_q, kept_count_d;
  logic [TopCountW-1:0] top_count_q, top_count_d;
  logic [FilesW-1:0]  files_q, files_d;
  logic [BytesW-1:0]  bytes_q, bytes_d;
  logic               ins_q, ins_d;
  logic               rd_ok_q, rd_ok_d;
  logic               is_read_q, is_read_d;
  logic [SizeW-1:0]   size_q, size_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic               out_valid_q, out_valid_d;

  logic               out_ins_q;
  logic [RankW-1:0]   out_rank_q;
  logic [FilesW-1:0]  out_files_q;
  logic [BytesW-1:0]  out_bytes_q;
  logic               out_ev_q;
  logic [SizeW-1:0]   out_size_q;
  logic [TagW-1:0]    out_tag_q;

  entry_t             mem [TOP_MAX];
  entry_t             rd_data_q;
  entry_t             wr_data;
  logic               mem_we, mem_re;
  logic [AW-1:0]      wr_addr, rd_addr;

  logic               in_acc, out_load;
  logic [CW-1:0]      lim, cfg_lim;
  logic [BytesW:0]    byte_sum;

  assign in_stall_o = (state_q != IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign lim        = limit_of(top_count_q);
  assign cfg_lim    = limit_of(cfg_wdata_i);
  assign byte_sum   = {1'b0, bytes_q} + (BytesW + 1)'(file_size_i);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    kept_count_d = kept_count_q;
    top_count_d  = top_count_q;
    files_d      = files_q;
    bytes_d      = bytes_q;
    ins_d        = ins_q;
    rd_ok_d      = rd_ok_q;
    is_read_d    = is_read_q;
    size_d       = size_q;
    tag_d        = tag_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_addr      = pos_q;
    wr_data      = '{size: size_q, tag: tag_q};
    rd_addr      = AW'(kept_count_q - 1'b1);
    out_load     = 1'b0;

    unique case (state_q)
      IDLE: begin
        if (in_acc) begin
          is_read_d = (action_i == ActionRead);
          size_d    = file_size_i;
          tag_d     = file_tag_i;
          ins_d     = 1'b0;
          rd_ok_d   = 1'b0;
          state_d   = DONE;
          if (action_i == ActionRead) begin
            rd_ok_d = (9'(read_rank_i) < 9'(kept_count_q)) &&
                      (9'(read_rank_i) < 9'(TOP_MAX));
            mem_re  = rd_ok_d;
            rd_addr = AW'(read_rank_i);
          end else begin
            if (files_q != '1) begin
              files_d = files_q + 1'b1;
            end
            bytes_d = byte_sum[BytesW] ? '1 : byte_sum[BytesW-1:0];
            if (lim != '0) begin
              if (kept_count_q < lim) begin
                kept_count_d = kept_count_q + 1'b1;
                pos_d        = AW'(kept_count_q);
                if (kept_count_q == '0) begin
                  state_d = PLACE;
                end else begin
                  mem_re  = 1'b1;
                  state_d = SCAN;
                end
              end else begin
                mem_re  = 1'b1;
                state_d = CHK;
              end
            end
          end
        end
      end
      CHK: begin
        if (size_q > rd_data_q.size) begin
          pos_d = AW'(kept_count_q - 1'b1);
          if (pos_d == '0) begin
            state_d = PLACE;
          end else begin
            mem_re  = 1'b1;
            rd_addr = pos_d - 1'b1;
            state_d = SCAN;
          end
        end else begin
          state_d = DONE;
        end
      end
      SCAN: begin
        mem_we = 1'b1;
        if (rd_data_q.size >= size_q) begin
          ins_d   = 1'b1;
          state_d = DONE;
        end else begin
          wr_data = rd_data_q;
          pos_d   = pos_q - 1'b1;
          if (pos_q == AW'(1)) begin
            state_d = PLACE;
          end else begin
            mem_re  = 1'b1;
            rd_addr = pos_q - AW'(2);
          end
        end
      end
      PLACE: begin
        mem_we  = 1'b1;
        ins_d   = 1'b1;
        state_d = DONE;
      end
      DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = IDLE;
        end
      end
      default: begin
        state_d = IDLE;
      end
    endcase

    if (cfg_we_i) begin
      top_count_d = cfg_wdata_i;
      if (kept_count_q > cfg_lim) begin
        kept_count_d = cfg_lim;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      kept_count_q <= '0;
      top_count_q  <= TopCountReset;
      files_q      <= '0;
      bytes_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      kept_count_q <= kept_count_d;
      top_count_q  <= top_count_d;
      files_q      <= files_d;
      bytes_q      <= bytes_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    ins_q     <= ins_d;
    rd_ok_q   <= rd_ok_d;
    is_read_q <= is_read_d;
    size_q    <= size_d;
    tag_q     <= tag_d;
    if (out_load) begin
      out_ins_q   <= ins_q;
      out_rank_q  <= ins_q ? RankW'(pos_q) : '0;
      out_files_q <= files_q;
      out_bytes_q <= bytes_q;
      out_ev_q    <= is_read_q && rd_ok_q;
      out_size_q  <= (is_read_q && rd_ok_q) ? rd_data_q.size : '0;
      out_tag_q   <= (is_read_q && rd_ok_q) ? rd_data_q.tag : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_inserted_o = out_ins_q;
  assign insert_rank_o  = out_rank_q;
  assign files_seen_o   = out_files_q;
  assign bytes_seen_o   = out_bytes_q;
  assign entry_valid_o  = out_ev_q;
  assign entry_size_o   = out_size_q;
  assign entry_tag_o    = out_tag_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_count_q <= lim)
    else $error("kept count above active limit");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != IDLE))
    else $error("accepted transaction left sequencer idle");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (wr_addr != rd_addr))
    else $error("read and write collide on one entry");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending transaction");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for top_k_largest_tracker: directed and random add and read transactions,
// each result checked field by field against an in-bench model of the sorted top-k list.
// Depends on tkl_pkg and the tracker RTL.
module tb_top;
  import tkl_pkg::*;

  localparam int unsigned TopMax     = TopMaxDefault;
  localparam logic [SizeW-1:0] SizeMax = '1;
  localparam logic [63:0] ByteLimit  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned PhaseItems = 195;

  typedef struct {
    logic              inserted;
    logic [RankW-1:0]  rank;
    logic [FilesW-1:0] files;
    logic [BytesW-1:0] bytes;
    logic              valid;
    logic [SizeW-1:0]  size;
    logic [TagW-1:0]   tag;
  } tracker_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [TopCountW-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 action_i    = ActionAdd;
  logic [SizeW-1:0]     file_size_i = '0;
  logic [TagW-1:0]      file_tag_i  = '0;
  logic [RankW-1:0]     read_rank_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 was_inserted_o;
  logic [RankW-1:0]     insert_rank_o;
  logic [FilesW-1:0]    files_seen_o;
  logic [BytesW-1:0]    bytes_seen_o;
  logic                 entry_valid_o;
  logic [SizeW-1:0]     entry_size_o;
  logic [TagW-1:0]      entry_tag_o;

  top_k_largest_tracker #(
    .TOP_MAX(TopMax)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .file_size_i    (file_size_i),
    .file_tag_i     (file_tag_i),
    .read_rank_i    (read_rank_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .was_inserted_o (was_inserted_o),
    .insert_rank_o  (insert_rank_o),
    .files_seen_o   (files_seen_o),
    .bytes_seen_o   (bytes_seen_o),
    .entry_valid_o  (entry_valid_o),
    .entry_size_o   (entry_size_o),
    .entry_tag_o    (entry_tag_o)
  );

  logic [SizeW-1:0]     kept_size_m [TopMax];
  logic [TagW-1:0]      kept_tag_m  [TopMax];
  int unsigned          kept_len     = 0;
  logic [TopCountW-1:0] top_count_m  = TopCountReset;
  logic [FilesW-1:0]    file_total_m = '0;
  logic [63:0]          byte_total_m = '0;
  logic [SizeW-1:0]     size_floor   = '0;

  tracker_result_t results_due[$];
  int unsigned     mismatch_count  = 0;
  int unsigned     items_sent      = 0;
  int unsigned     results_checked = 0;
  int unsigned     inserts_seen    = 0;
  bit              steady_flow     = 1'b0;

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(0, 99) < 10);
  end

  function automatic int unsigned kept_limit();
    return (top_count_m < TopMax) ? top_count_m : TopMax;
  endfunction

  function automatic tracker_result_t rank_file_item(input logic act,
                                                     input logic [SizeW-1:0] sz,
                                                     input logic [TagW-1:0] tg,
                                                     input logic [RankW-1:0] rk);
    tracker_result_t r;
    int unsigned     lim;
    int unsigned     pos;
    int unsigned     last;
    bit              ins;
    r   = '{default: '0};
    ins = 1'b0;
    pos = 0;
    if (act == ActionAdd) begin
      lim = kept_limit();
      if (file_total_m != '1) file_total_m++;
      byte_total_m = byte_total_m + sz;
      if (byte_total_m > ByteLimit) byte_total_m = ByteLimit;
      if (lim > 0) begin
        if (kept_len < lim) begin
          last = kept_len;
          kept_len++;
          ins = 1'b1;
        end else if (kept_len > 0 && sz > kept_size_m[kept_len-1]) begin
          last = kept_len - 1;
          ins  = 1'b1;
        end
        if (ins) begin
          while (pos < last && kept_size_m[pos] >= sz) pos++;
          for (int i = last; i > pos; i--) begin
            kept_size_m[i] = kept_size_m[i-1];
            kept_tag_m[i]  = kept_tag_m[i-1];
          end
          kept_size_m[pos] = sz;
          kept_tag_m[pos]  = tg;
          r.inserted = 1'b1;
          r.rank     = pos[RankW-1:0];
        end
      end
    end else if (rk < kept_len) begin
      r.valid = 1'b1;
      r.size  = kept_size_m[rk];
      r.tag   = kept_tag_m[rk];
    end
    r.files = file_total_m;
    r.bytes = byte_total_m[BytesW-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    $display("mismatch on %s at result %0d: got %0h, want %0h",
             what, results_checked, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    tracker_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        flag_mismatch("result with none pending", 64'd0, 64'd0);
      end else begin
        want = results_due.pop_front();
        if (was_inserted_o !== want.inserted)
          flag_mismatch("was_inserted", 64'(was_inserted_o), 64'(want.inserted));
        if (insert_rank_o !== want.rank)
          flag_mismatch("insert_rank", 64'(insert_rank_o), 64'(want.rank));
        if (files_seen_o !== want.files)
          flag_mismatch("files_seen", 64'(files_seen_o), 64'(want.files));
        if (bytes_seen_o !== want.bytes)
          flag_mismatch("bytes_seen", 64'(bytes_seen_o), 64'(want.bytes));
        if (entry_valid_o !== want.valid)
          flag_mismatch("entry_valid", 64'(entry_valid_o), 64'(want.valid));
        if (entry_size_o !== want.size)
          flag_mismatch("entry_size", 64'(entry_size_o), 64'(want.size));
        if (entry_tag_o !== want.tag)
          flag_mismatch("entry_tag", 64'(entry_tag_o), 64'(want.tag));
        if (was_inserted_o === 1'b1) inserts_seen++;
        results_checked++;
      end
    end
  end

  function automatic logic [SizeW-1:0] rand_size();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[SizeW-1:0];
  endfunction

  task automatic send_item(input logic act, input logic [SizeW-1:0] sz,
                           input logic [TagW-1:0] tg, input logic [RankW-1:0] rk);
    int unsigned gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 10) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    file_size_i <= sz;
    file_tag_i  <= tg;
    read_rank_i <= rk;
    do @(posedge clk_i); while (in_stall_o);
    results_due.insert(results_due.size(), rank_file_item(act, sz, tg, rk));
    items_sent++;
  endtask

  task automatic add_file(input logic [SizeW-1:0] sz, input logic [TagW-1:0] tg);
    send_item(ActionAdd, sz, tg, RankW'($urandom_range(0, 31)));
  endtask

  task automatic read_entry(input logic [RankW-1:0] rk);
    send_item(ActionRead, rand_size(), $urandom, rk);
  endtask

  // drop valid and hold until the block has delivered everything
  task automatic wait_all_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_top_count(input logic [TopCountW-1:0] value);
    wait_all_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    top_count_m = value;
    if (kept_len > kept_limit()) kept_len = kept_limit();
  endtask

  task automatic test_fill_and_ties();
    read_entry(0);
    add_file(SizeMax, '1);
    add_file('0, '0);
    add_file(48'd100, 32'hA5A5_0001);
    add_file(48'd100, 32'h5A5A_0002);
    for (int r = 0; r < 4; r++) read_entry(RankW'(r));
    read_entry('1);
  endtask

  task automatic test_full_list();
    write_top_count(6'd2);
    read_entry(1);
    read_entry(2);
    add_file(48'd100, 32'h0000_0003);
    add_file(48'd101, 32'h0000_0004);
    add_file('0, 32'h0000_0005);
    read_entry(1);
  endtask

  task automatic test_tracking_off();
    write_top_count('0);
    add_file(SizeMax, 32'h0000_FFFF);
    read_entry(0);
  endtask

  task automatic test_wide_count();
    write_top_count('1);
    add_file(48'h8000_0000_0000, 32'hFFFF_0000);
    add_file(48'h1, 32'h1234_5678);
    read_entry(1);
    write_top_count(TopCountW'(TopMax));
  endtask

  task automatic test_random_traffic();
    logic [TopCountW-1:0] counts [9];
    logic [SizeW-1:0]     sz;
    int unsigned          mode;
    counts = '{6'd20, 6'd1, 6'd32, 6'd63, 6'd3, 6'd0, 6'd17, 6'd32, 6'd0};
    counts[8] = TopCountW'($urandom_range(0, 63));
    for (int ph = 0; ph < 9; ph++) begin
      write_top_count(counts[ph]);
      steady_flow = (ph == 4);
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 2 && i == PhaseItems / 2) wait_all_results();
        size_floor = size_floor + SizeW'($urandom_range(0, 8));
        if ($urandom_range(0, 99) < 30) begin
          read_entry(RankW'($urandom_range(0, 31)));
        end else begin
          mode = $urandom_range(0, 99);
          if (mode < 40)      sz = size_floor + SizeW'($urandom_range(0, 15));
          else if (mode < 60) sz = SizeW'($urandom_range(0, 31));
          else if (mode < 85) sz = rand_size();
          else if (mode < 95) sz = rand_size() >> $urandom_range(1, 47);
          else                sz = ($urandom_range(0, 1) != 0) ? SizeMax : '0;
          add_file(sz, $urandom);
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_fill_and_ties();
    test_full_list();
    test_tracking_off();
    test_wide_count();
    test_random_traffic();
    wait_all_results();
    repeat (TopMax + 8) @(posedge clk_i);
    $display("Ran %0d transactions, %0d results checked, %0d insertions seen;",
             items_sent, results_checked, inserts_seen);
    $display("top_count from 0 to 63, ties, replacement of the smallest, shrinking.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timed out with %0d results pending", results_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tkl_pkg.sv
rtl/top_k_largest_tracker.sv
dv/tb_top.sv
